### design/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared widths, side-band payload types and the t factor table for the
// sample statistics pipeline.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int CNT_W   = 16;
  localparam int SUM_W   = 40;
  localparam int SQ_W    = 64;
  localparam int FRAC    = 8;
  localparam int MEAN_W  = 32;
  localparam int SD_W    = 32;
  localparam int IV_W    = 34;
  localparam int TF_W    = 12;
  localparam int NUM_W   = CNT_W + SQ_W;
  localparam int DEN_W   = 2 * CNT_W;
  localparam int VAR_W   = 2 * SD_W;
  localparam int ROOT_REM_W = SD_W + 2;
  localparam int TREM_W  = 10;
  localparam int TFR_W   = TREM_W + TF_W;
  localparam int QT_W    = 23;
  localparam int T_RECIP_W  = 29;
  localparam int T_RECIP_SH = 38;
  localparam logic [TREM_W-1:0]    T_SCALE = 10'd1000;
  // ceil(2^38 / 1000), exact quotient by 1000 for any 32-bit operand
  localparam logic [T_RECIP_W-1:0] T_RECIP = 29'd274877907;

  typedef struct packed {
    logic                ok;
    logic                sat;
    logic [CNT_W-1:0]    n;
    logic [SUM_W-1:0]    s;
    logic [SQ_W-1:0]     q;
  } mean_side_t;

  typedef struct packed {
    logic                ok;
    logic                sat;
    logic [MEAN_W-1:0]   mean;
    logic [CNT_W-1:0]    n;
  } var_side_t;

  typedef struct packed {
    logic                ok;
    logic [MEAN_W-1:0]   mean;
    logic [CNT_W-1:0]    n;
  } root_side_t;

  typedef struct packed {
    logic                ok;
    logic [MEAN_W-1:0]   mean;
    logic [SD_W-1:0]     sd;
  } iv_side_t;

  function automatic logic [TF_W-1:0] t_factor(input logic [CNT_W-1:0] dof);
    logic [TF_W-1:0] t;
    t = '0;
    if (dof >= CNT_W'(100)) begin
      t = 12'd1290;
    end else if (dof >= CNT_W'(50)) begin
      t = 12'd1300;
    end else if (dof >= CNT_W'(30)) begin
      t = 12'd1310;
    end else if (dof >= CNT_W'(20)) begin
      t = 12'd1325;
    end else begin
      case (dof[4:0])
        5'd1:    t = 12'd3078;
        5'd2:    t = 12'd1886;
        5'd3:    t = 12'd1638;
        5'd4:    t = 12'd1533;
        5'd5:    t = 12'd1476;
        5'd6:    t = 12'd1440;
        5'd7:    t = 12'd1415;
        5'd8:    t = 12'd1397;
        5'd9:    t = 12'd1383;
        5'd10:   t = 12'd1372;
        5'd11:   t = 12'd1363;
        5'd12:   t = 12'd1356;
        5'd13:   t = 12'd1350;
        5'd14:   t = 12'd1345;
        5'd15:   t = 12'd1341;
        5'd16:   t = 12'd1337;
        5'd17:   t = 12'd1333;
        5'd18:   t = 12'd1330;
        5'd19:   t = 12'd1328;
        default: t = '0;
      endcase
    end
    return t;
  endfunction

endpackage

### design/ssc_div_cell.sv
// ----------------------------------------------------------------------------
// ssc_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder and one quotient bit into the dividend/quotient register.
// ----------------------------------------------------------------------------
module ssc_div_cell #(
  parameter int DW = 16,
  parameter int QW = 32,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          vld_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [QW-1:0] dq_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [DW-1:0] rem_o,
  output logic [DW-1:0] div_o,
  output logic [QW-1:0] dq_o,
  output logic [SW-1:0] side_o
);

  logic          vld_r;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] div_r;
  logic [QW-1:0] dq_r, dq_nxt;
  logic [SW-1:0] side_r;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  always_comb begin
    trial   = {rem_i, dq_i[QW-1]};
    diff    = trial - {1'b0, div_i};
    ge      = trial >= {1'b0, div_i};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    dq_nxt  = {dq_i[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    div_r  <= div_i;
    dq_r   <= dq_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign div_o  = div_r;
  assign dq_o   = dq_r;
  assign side_o = side_r;

endmodule

### design/ssc_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ssc_sqrt_cell
// One digit-by-digit integer square root step: brings down two radicand
// bits and settles one root bit.
// ----------------------------------------------------------------------------
module ssc_sqrt_cell #(
  parameter int SW = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld_i,
  input  logic [ssc_pkg::ROOT_REM_W-1:0]      rem_i,
  input  logic [ssc_pkg::SD_W-1:0]            root_i,
  input  logic [ssc_pkg::VAR_W-1:0]           rad_i,
  input  logic [SW-1:0]                       side_i,
  output logic                                vld_o,
  output logic [ssc_pkg::ROOT_REM_W-1:0]      rem_o,
  output logic [ssc_pkg::SD_W-1:0]            root_o,
  output logic [ssc_pkg::VAR_W-1:0]           rad_o,
  output logic [SW-1:0]                       side_o
);

  localparam int CW = ssc_pkg::ROOT_REM_W + 2;

  logic                               vld_r;
  logic [ssc_pkg::ROOT_REM_W-1:0]     rem_r, rem_nxt;
  logic [ssc_pkg::SD_W-1:0]           root_r, root_nxt;
  logic [ssc_pkg::VAR_W-1:0]          rad_r;
  logic [SW-1:0]                      side_r;
  logic [CW-1:0]                      cur;
  logic [CW-1:0]                      trial;
  logic [CW-1:0]                      diff;
  logic                               ge;

  always_comb begin
    cur      = {rem_i, rad_i[ssc_pkg::VAR_W-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    diff     = cur - trial;
    ge       = cur >= trial;
    rem_nxt  = ge ? diff[ssc_pkg::ROOT_REM_W-1:0] : cur[ssc_pkg::ROOT_REM_W-1:0];
    root_nxt = {root_i[ssc_pkg::SD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    rad_r  <= {rad_i[ssc_pkg::VAR_W-3:0], 2'b00};
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;
  assign rad_o  = rad_r;
  assign side_o = side_r;

endmodule

### design/sample_stats_confidence.sv
// ----------------------------------------------------------------------------
// sample_stats_confidence
// Mean, sample standard deviation and 80% t confidence half-width from a
// sample count, sum and sum of squares; the results have 8 fraction bits.
// ----------------------------------------------------------------------------
//  channel  ports                          handshake
//  input    in_sample_count/sum/square_sum start & !busy
//  result   out_*                          out_valid, one-cycle strobe
//
//  One transaction per cycle; busy is always low. A transaction passes through
//  32 mean division cells, 3 multiply/add stages, 64 variance division
//  cells, 32 square root cells, 3 t scaling stages and the output
//  register. Reset clears only the valid bits of the chain.
//  The receiver cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module sample_stats_confidence (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ssc_pkg::CNT_W-1:0]     in_sample_count,
  input  logic [ssc_pkg::SUM_W-1:0]     in_sample_sum,
  input  logic [ssc_pkg::SQ_W-1:0]      in_square_sum,
  output logic                          out_valid,
  output logic                          out_enough_samples,
  output logic [ssc_pkg::MEAN_W-1:0]    out_mean_q8,
  output logic [ssc_pkg::SD_W-1:0]      out_std_dev_q8,
  output logic [ssc_pkg::IV_W-1:0]      out_interval_q8
);

  localparam int CW   = ssc_pkg::CNT_W;
  localparam int MQ   = ssc_pkg::MEAN_W;
  localparam int VQ   = ssc_pkg::VAR_W;
  localparam int RQ   = ssc_pkg::SD_W;
  localparam int IQ   = ssc_pkg::IV_W;
  localparam int NQW  = CW + 32;
  localparam int DNW  = ssc_pkg::DEN_W;
  localparam int RCW  = ssc_pkg::T_RECIP_W;
  localparam int RPW  = RQ + RCW;
  localparam int TRW  = ssc_pkg::TFR_W;
  localparam int YPW  = TRW + RCW;
  localparam int QTW  = ssc_pkg::QT_W;
  localparam int MSW  = $bits(ssc_pkg::mean_side_t);
  localparam int VSW  = $bits(ssc_pkg::var_side_t);
  localparam int RSW  = $bits(ssc_pkg::root_side_t);
  localparam int LAT  = MQ + 3 + VQ + RQ + 3 + 1;

  // mean division chain
  logic                 m_vld  [0:MQ];
  logic [CW-1:0]        m_rem  [0:MQ];
  logic [CW-1:0]        m_div  [0:MQ];
  logic [MQ-1:0]        m_dq   [0:MQ];
  logic [MSW-1:0]       m_side [0:MQ];
  ssc_pkg::mean_side_t  m_in_side, m_out_side;
  logic [CW-1:0]        m_hi;

  always_comb begin
    m_hi               = in_sample_sum[ssc_pkg::SUM_W-1 -: CW];
    m_in_side.ok       = in_sample_count >= CW'(2);
    m_in_side.sat      = m_hi >= in_sample_count;
    m_in_side.n        = in_sample_count;
    m_in_side.s        = in_sample_sum;
    m_in_side.q        = in_square_sum;
  end

  assign m_vld[0]  = start & ~busy;
  assign m_rem[0]  = m_in_side.sat ? '0 : m_hi;
  assign m_div[0]  = in_sample_count;
  assign m_dq[0]   = {in_sample_sum[MQ-ssc_pkg::FRAC-1:0], {ssc_pkg::FRAC{1'b0}}};
  assign m_side[0] = m_in_side;

  for (genvar k = 0; k < MQ; k++) begin : g_mean
    ssc_div_cell #(.DW(CW), .QW(MQ), .SW(MSW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (m_vld[k]),
      .rem_i  (m_rem[k]),
      .div_i  (m_div[k]),
      .dq_i   (m_dq[k]),
      .side_i (m_side[k]),
      .vld_o  (m_vld[k+1]),
      .rem_o  (m_rem[k+1]),
      .div_o  (m_div[k+1]),
      .dq_o   (m_dq[k+1]),
      .side_o (m_side[k+1])
    );
  end

  assign m_out_side = m_side[MQ];

  // products
  logic                       p1_vld_r;
  logic [NQW-1:0]             p1_nq0_r, p1_nq1_r;
  logic [63:0]                p1_ssl_r;
  logic [39:0]                p1_ssm_r;
  logic [15:0]                p1_ssh_r;
  logic [DNW-1:0]             p1_den_r;
  logic [CW-1:0]              p1_n_r;
  logic [MQ-1:0]              p1_mean_r;
  logic                       p1_ok_r;
  logic [31:0]                s_lo;
  logic [7:0]                 s_hi;

  assign s_lo = m_out_side.s[31:0];
  assign s_hi = m_out_side.s[39:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= m_vld[MQ];
    end
  end

  always_ff @(posedge clk) begin
    p1_nq0_r  <= NQW'(m_out_side.n) * NQW'(m_out_side.q[31:0]);
    p1_nq1_r  <= NQW'(m_out_side.n) * NQW'(m_out_side.q[63:32]);
    p1_ssl_r  <= 64'(s_lo) * 64'(s_lo);
    p1_ssm_r  <= 40'(s_hi) * 40'(s_lo);
    p1_ssh_r  <= 16'(s_hi) * 16'(s_hi);
    p1_den_r  <= DNW'(m_out_side.n) * DNW'(m_out_side.n - CW'(1));
    p1_n_r    <= m_out_side.n;
    p1_mean_r <= m_out_side.sat ? '1 : m_dq[MQ];
    p1_ok_r   <= m_out_side.ok;
  end

  // sums
  logic                       p2_vld_r;
  logic [ssc_pkg::NUM_W-1:0]  p2_nq_r, p2_nq_nxt, p2_ss_r, p2_ss_nxt;
  logic [DNW-1:0]             p2_den_r;
  logic [CW-1:0]              p2_n_r;
  logic [MQ-1:0]              p2_mean_r;
  logic                       p2_ok_r;

  assign p2_nq_nxt = {32'b0, p1_nq0_r} + {p1_nq1_r, 32'b0};
  assign p2_ss_nxt = {16'b0, p1_ssl_r} + {7'b0, p1_ssm_r, 33'b0} + {p1_ssh_r, 64'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p2_nq_r   <= p2_nq_nxt;
    p2_ss_r   <= p2_ss_nxt;
    p2_den_r  <= p1_den_r;
    p2_n_r    <= p1_n_r;
    p2_mean_r <= p1_mean_r;
    p2_ok_r   <= p1_ok_r;
  end

  // clamped numerator
  logic                       p3_vld_r;
  logic [ssc_pkg::NUM_W-1:0]  p3_num_r, p3_num_nxt;
  logic [DNW-1:0]             p3_den_r;
  logic [CW-1:0]              p3_n_r;
  logic [MQ-1:0]              p3_mean_r;
  logic                       p3_ok_r;

  assign p3_num_nxt = (p2_nq_r > p2_ss_r) ? (p2_nq_r - p2_ss_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p3_num_r  <= p3_num_nxt;
    p3_den_r  <= p2_den_r;
    p3_n_r    <= p2_n_r;
    p3_mean_r <= p2_mean_r;
    p3_ok_r   <= p2_ok_r;
  end

  // variance division chain: num * 2^16 / den, saturated to 64 bits
  logic                       v_vld  [0:VQ];
  logic [DNW-1:0]             v_rem  [0:VQ];
  logic [DNW-1:0]             v_div  [0:VQ];
  logic [VQ-1:0]              v_dq   [0:VQ];
  logic [VSW-1:0]             v_side [0:VQ];
  ssc_pkg::var_side_t         v_in_side, v_out_side;
  logic [DNW-1:0]             v_hi;

  always_comb begin
    v_hi           = p3_num_r[ssc_pkg::NUM_W-1 -: DNW];
    v_in_side.ok   = p3_ok_r;
    v_in_side.sat  = v_hi >= p3_den_r;
    v_in_side.mean = p3_mean_r;
    v_in_side.n    = p3_n_r;
  end

  assign v_vld[0]  = p3_vld_r;
  assign v_rem[0]  = v_in_side.sat ? '0 : v_hi;
  assign v_div[0]  = p3_den_r;
  assign v_dq[0]   = {p3_num_r[VQ-2*ssc_pkg::FRAC-1:0], {(2*ssc_pkg::FRAC){1'b0}}};
  assign v_side[0] = v_in_side;

  for (genvar k = 0; k < VQ; k++) begin : g_var
    ssc_div_cell #(.DW(DNW), .QW(VQ), .SW(VSW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (v_vld[k]),
      .rem_i  (v_rem[k]),
      .div_i  (v_div[k]),
      .dq_i   (v_dq[k]),
      .side_i (v_side[k]),
      .vld_o  (v_vld[k+1]),
      .rem_o  (v_rem[k+1]),
      .div_o  (v_div[k+1]),
      .dq_o   (v_dq[k+1]),
      .side_o (v_side[k+1])
    );
  end

  assign v_out_side = v_side[VQ];

  // square root chain
  logic                            r_vld  [0:RQ];
  logic [ssc_pkg::ROOT_REM_W-1:0]  r_rem  [0:RQ];
  logic [RQ-1:0]                   r_root [0:RQ];
  logic [VQ-1:0]                   r_rad  [0:RQ];
  logic [RSW-1:0]                  r_side [0:RQ];
  ssc_pkg::root_side_t             r_in_side, r_out_side;

  always_comb begin
    r_in_side.ok   = v_out_side.ok;
    r_in_side.mean = v_out_side.mean;
    r_in_side.n    = v_out_side.n;
  end

  assign r_vld[0]  = v_vld[VQ];
  assign r_rem[0]  = '0;
  assign r_root[0] = '0;
  assign r_rad[0]  = v_out_side.sat ? '1 : v_dq[VQ];
  assign r_side[0] = r_in_side;

  for (genvar k = 0; k < RQ; k++) begin : g_root
    ssc_sqrt_cell #(.SW(RSW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (r_vld[k]),
      .rem_i  (r_rem[k]),
      .root_i (r_root[k]),
      .rad_i  (r_rad[k]),
      .side_i (r_side[k]),
      .vld_o  (r_vld[k+1]),
      .rem_o  (r_rem[k+1]),
      .root_o (r_root[k+1]),
      .rad_o  (r_rad[k+1]),
      .side_o (r_side[k+1])
    );
  end

  assign r_out_side = r_side[RQ];

  // t scaling: sd * t / 1000 = (sd / 1000) * t + (sd % 1000) * t / 1000
  logic                        p4_vld_r;
  logic [QTW-1:0]              p4_qr_r;
  logic [ssc_pkg::TF_W-1:0]    p4_tf_r;
  ssc_pkg::iv_side_t           p4_side_r;
  logic [RPW-1:0]              p4_recip;

  assign p4_recip = RPW'(r_root[RQ]) * RPW'(ssc_pkg::T_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else begin
      p4_vld_r <= r_vld[RQ];
    end
  end

  always_ff @(posedge clk) begin
    p4_qr_r        <= p4_recip[ssc_pkg::T_RECIP_SH +: QTW];
    p4_tf_r        <= ssc_pkg::t_factor(r_out_side.n - CW'(1));
    p4_side_r.ok   <= r_out_side.ok;
    p4_side_r.mean <= r_out_side.mean;
    p4_side_r.sd   <= r_root[RQ];
  end

  logic                        p5_vld_r;
  logic [ssc_pkg::TREM_W-1:0]  p5_rr_r;
  logic [IQ-1:0]               p5_qt_r;
  logic [ssc_pkg::TF_W-1:0]    p5_tf_r;
  ssc_pkg::iv_side_t           p5_side_r;
  logic [RQ-1:0]               p5_rr_full;

  assign p5_rr_full = p4_side_r.sd - RQ'(p4_qr_r) * RQ'(ssc_pkg::T_SCALE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_vld_r <= 1'b0;
    end else begin
      p5_vld_r <= p4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p5_rr_r   <= p5_rr_full[ssc_pkg::TREM_W-1:0];
    p5_qt_r   <= IQ'(p4_qr_r) * IQ'(p4_tf_r);
    p5_tf_r   <= p4_tf_r;
    p5_side_r <= p4_side_r;
  end

  logic                        p6_vld_r;
  logic [TRW-1:0]              p6_y_r;
  logic [IQ-1:0]               p6_qt_r;
  ssc_pkg::iv_side_t           p6_side_r;
  logic [YPW-1:0]              p6_frac;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p6_vld_r <= 1'b0;
    end else begin
      p6_vld_r <= p5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p6_y_r    <= TRW'(p5_rr_r) * TRW'(p5_tf_r);
    p6_qt_r   <= p5_qt_r;
    p6_side_r <= p5_side_r;
  end

  assign p6_frac = YPW'(p6_y_r) * YPW'(ssc_pkg::T_RECIP);

  // output register
  logic           out_valid_r;
  logic           out_ok_r;
  logic [MQ-1:0]  out_mean_r;
  logic [RQ-1:0]  out_sd_r;
  logic [IQ-1:0]  out_iv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r   <= p6_vld_r & p6_side_r.ok;
    out_mean_r <= p6_side_r.ok ? p6_side_r.mean : '0;
    out_sd_r   <= p6_side_r.ok ? p6_side_r.sd : '0;
    out_iv_r   <= p6_side_r.ok ?
                  (p6_qt_r + IQ'(p6_frac[YPW-1:ssc_pkg::T_RECIP_SH])) : '0;
  end

  assign busy               = 1'b0;
  assign out_valid          = out_valid_r;
  assign out_enough_samples = out_ok_r;
  assign out_mean_q8        = out_mean_r;
  assign out_std_dev_q8     = out_sd_r;
  assign out_interval_q8    = out_iv_r;

`ifndef SYNTH
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching transaction");

  a_iv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_interval_q8 <= {out_std_dev_q8, 2'b00}))
    else $error("interval exceeds t factor bound");

  a_iv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_std_dev_q8 == '0) |-> (out_interval_q8 == '0))
    else $error("nonzero interval with zero deviation");
`endif

endmodule
